>>> rtl/assert_macros.svh
// Assertion macros for the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of i_clk while reset is released.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Checks a property on every rising edge of i_clk, reset included.
`define ASSERT_CLK_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/dmst_pkg.sv
// Types and constants for the direct-mapped statistics table.
package dmst_pkg;

    localparam int DMST_TABLE_DEPTH = 4096;

    localparam int KEY_W   = 64;
    localparam int TOTAL_W = 32;
    localparam int VL_W    = 16;
    localparam int REQ_W   = 2;

    localparam logic [VL_W-1:0] VL_RESET = 16'd256;

    // Request type codes.
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACCUM  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_VLOSS  = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [TOTAL_W-1:0] wins;
        logic [TOTAL_W-1:0] sims;
    } t_entry;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

>>> rtl/direct_mapped_stats_table.sv
// Top level of the direct-mapped statistics table: memory, read-modify-write and output stage.
//
//  Channel   Signals                                        Direction
//  -------   --------------------------------------------   ---------
//  request   i_valid, o_ready, i_req_type, i_position_key,  in
//            i_wins_add, i_sims_add
//  result    o_valid, i_ready, o_hit, o_wins_total,         out
//            o_sims_total, o_saturated
//  config    i_cfg_we, i_cfg_wdata                          in
//
// A request beat is taken every cycle when results drain; the memory read is registered together
// with the request in the single read-modify-write stage, and its result then goes into the result
// register, from which it is offered. The written entry is forwarded to a following request
// for the same entry. After reset a clearing pass marks every entry invalid; no request is
// taken during it, configuration writes are. When the result register is held by the consumer,
// the stage behind it holds its item and o_ready drops.

`include "assert_macros.svh"

module direct_mapped_stats_table
    import dmst_pkg::*;
#(
    parameter int TABLE_DEPTH = DMST_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [KEY_W-1:0]   i_position_key,
    input  logic [TOTAL_W-1:0] i_wins_add,
    input  logic [TOTAL_W-1:0] i_sims_add,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic [TOTAL_W-1:0] o_wins_total,
    output logic [TOTAL_W-1:0] o_sims_total,
    output logic               o_saturated,
    // configuration
    input  logic               i_cfg_we,
    input  logic [VL_W-1:0]    i_cfg_wdata
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    // Configuration register: virtual-loss amount, Q8.8, same fraction bits as the totals.
    logic [VL_W-1:0] r_vl_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl_amount <= VL_RESET;
        end else if (i_cfg_we) begin
            r_vl_amount <= i_cfg_wdata;
        end
    end

    // Control state: clearing pass after reset, then normal operation.
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;

    // Read-modify-write stage holding the item and the memory word read for it.
    logic               r_s1_valid;
    logic [REQ_W-1:0]   r_s1_req;
    logic [KEY_W-1:0]   r_s1_key;
    logic [TOTAL_W-1:0] r_s1_wadd;
    logic [TOTAL_W-1:0] r_s1_sadd;
    logic               r_fwd;
    t_entry             r_fwd_data;
    t_entry             r_rd_data;

    // Output register.
    logic               r_out_valid;
    logic               r_out_hit;
    logic [TOTAL_W-1:0] r_out_wins;
    logic [TOTAL_W-1:0] r_out_sims;
    logic               r_out_sat;

    // Entry memory: valid bit, full key as tag, and both totals in one word.
    t_entry mem [TABLE_DEPTH];

    logic               accept;
    logic               s1_adv;
    logic               clr_we;
    logic               fwd_match;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    t_entry             mem_wd;

    t_entry             ent;
    logic               ent_hit;
    logic               is_upd;
    logic [TOTAL_W-1:0] wadd;
    logic [TOTAL_W-1:0] sadd;
    logic [TOTAL_W-1:0] wbase;
    logic [TOTAL_W-1:0] sbase;
    logic [TOTAL_W:0]   wsum;
    logic [TOTAL_W:0]   ssum;
    logic [TOTAL_W-1:0] wnew;
    logic [TOTAL_W-1:0] snew;
    logic               sat;
    logic               res_hit;
    logic [TOTAL_W-1:0] res_wins;
    logic [TOTAL_W-1:0] res_sims;
    logic               res_sat;
    t_entry             upd_entry;

    // Next state: the clearing pass ends once the last entry has been written.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // The stage moves on whenever the output register is free or being emptied.
    assign s1_adv = r_s1_valid && (!r_out_valid || i_ready);

    // State outputs: clearing writes, and request acceptance in normal operation.
    always_comb begin
        clr_we  = 1'b0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                clr_we = 1'b1;
            end
            ST_RUN: begin
                o_ready = !r_s1_valid || s1_adv;
            end
            default: begin
                clr_we = 1'b0;
            end
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // The stage sees the memory word, or the entry written back by the item just ahead of it
    // when both map to the same entry (the memory read in that cycle still gave the old word).
    assign ent = r_fwd ? r_fwd_data : r_rd_data;
    assign ent_hit = ent.valid && (ent.key == r_s1_key);

    always_comb begin
        case (r_s1_req) inside
            REQ_ACCUM, REQ_VLOSS: is_upd = 1'b1;
            REQ_LOOKUP:           is_upd = 1'b0;
            default:              is_upd = 1'b0;    // the unused code behaves as a lookup
        endcase
    end

    always_comb begin
        if (r_s1_req == REQ_VLOSS) begin
            wadd = '0;
            sadd = {{(TOTAL_W-VL_W){1'b0}}, r_vl_amount};
        end else begin
            wadd = r_s1_wadd;
            sadd = r_s1_sadd;
        end
        // A miss claims the entry with cleared totals before adding.
        wbase = ent_hit ? ent.wins : '0;
        sbase = ent_hit ? ent.sims : '0;
        wsum  = {1'b0, wbase} + {1'b0, wadd};
        ssum  = {1'b0, sbase} + {1'b0, sadd};
        wnew  = wsum[TOTAL_W] ? {TOTAL_W{1'b1}} : wsum[TOTAL_W-1:0];
        snew  = ssum[TOTAL_W] ? {TOTAL_W{1'b1}} : ssum[TOTAL_W-1:0];
        sat   = wsum[TOTAL_W] || ssum[TOTAL_W];

        upd_entry.valid = 1'b1;
        upd_entry.key   = r_s1_key;
        upd_entry.wins  = wnew;
        upd_entry.sims  = snew;

        res_hit = ent_hit;
        if (is_upd) begin
            res_wins = wnew;
            res_sims = snew;
            res_sat  = sat;
        end else begin
            res_wins = ent_hit ? ent.wins : '0;
            res_sims = ent_hit ? ent.sims : '0;
            res_sat  = 1'b0;
        end
    end

    // One write port, shared by the clearing pass and the write-back of updates.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_s1_key[ADDR_W-1:0];
        mem_wd = upd_entry;
        if (clr_we) begin
            mem_we       = 1'b1;
            mem_wa       = r_clr_addr;
            mem_wd       = '0;
        end else if (s1_adv && is_upd) begin
            mem_we = 1'b1;
        end
    end

    assign fwd_match = s1_adv && is_upd
                    && (i_position_key[ADDR_W-1:0] == r_s1_key[ADDR_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rd_data <= mem[i_position_key[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= fwd_match;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req   <= i_req_type;
            r_s1_key   <= i_position_key;
            r_s1_wadd  <= i_wins_add;
            r_s1_sadd  <= i_sims_add;
            r_fwd_data <= upd_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_hit  <= res_hit;
            r_out_wins <= res_wins;
            r_out_sims <= res_sims;
            r_out_sat  <= res_sat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_wins_total = r_out_wins;
    assign o_sims_total = r_out_sims;
    assign o_saturated  = r_out_sat;

    // A new request never lands on an item that has not moved on.
    `ASSERT_CLK(a_no_overrun, accept |-> (!r_s1_valid || s1_adv))
    // Forwarded data only ever belongs to an item in the stage.
    `ASSERT_CLK(a_fwd_owned, r_fwd |-> r_s1_valid)
    // Normal operation starts only after the clearing pass reached the last entry.
    `ASSERT_CLK(a_clear_done,
        ((r_state == ST_RUN) && $past(r_state == ST_CLEAR)) |-> $past(&r_clr_addr))

endmodule
